[rtl/hsa_pkg.sv]
// Shared types, constants and helper functions of the HSL saturation adjust core.
package hsa_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned FX_W      = FRAC_BITS + 1;
  localparam int unsigned DEN_W     = FRAC_BITS + 2;
  localparam int unsigned DIV_STEPS = FRAC_BITS + 1;
  localparam int unsigned INT_W     = 10;

  localparam logic [FX_W-1:0]  ONE   = FX_W'(1) << FRAC_BITS;
  localparam logic [FX_W-1:0]  HALF  = FX_W'(ONE / 2);
  localparam logic [FX_W-1:0]  THIRD = FX_W'(ONE / 3);
  localparam logic [FX_W-1:0]  SIXTH = FX_W'(ONE / 6);
  localparam logic [FX_W-1:0]  TWO3  = FX_W'((2 * ONE) / 3);
  localparam logic [DEN_W-1:0] TWO   = DEN_W'(2 * ONE);

  localparam logic [18:0] RECIP3 = 19'd349526;
  localparam logic [21:0] RECIP5 = 22'd3355444;

  localparam logic [0:0] CFG_INTENSITY = 1'b0;
  localparam logic [0:0] CFG_ENABLE    = 1'b1;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;

  typedef struct packed {
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic            last;
    logic            bypass;
    logic [FX_W-1:0] light;
    logic            hneg;
    logic            wrap6;
    sector_e         sector;
  } item_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem_s;
    logic [DEN_W-1:0] den_s;
    logic [FX_W-1:0]  quo_s;
    logic [DEN_W-1:0] rem_h;
    logic [DEN_W-1:0] den_h;
    logic [FX_W-1:0]  quo_h;
  } div_t;

  function automatic logic [FX_W-1:0] to_fx(input logic [7:0] c);
    logic [FX_W-1:0] v;
    v = FX_W'({c, 8'b0}) + FX_W'(c) + FX_W'(c == 8'hFF);
    return v;
  endfunction

  function automatic void div_bit(input logic [DEN_W-1:0] rem, input logic [DEN_W-1:0] den,
                                  input logic first, output logic [DEN_W-1:0] rem_n,
                                  output logic qbit);
    logic [DEN_W:0] t;
    t = first ? {1'b0, rem} : {rem, 1'b0};
    qbit = (t >= {1'b0, den});
    rem_n = qbit ? DEN_W'(t - {1'b0, den}) : t[DEN_W-1:0];
  endfunction

  function automatic div_t div_step(input div_t din, input logic first);
    div_t o;
    logic bs;
    logic bh;
    o = din;
    div_bit(din.rem_s, din.den_s, first, o.rem_s, bs);
    div_bit(din.rem_h, din.den_h, first, o.rem_h, bh);
    o.quo_s = {din.quo_s[FX_W-2:0], bs};
    o.quo_h = {din.quo_h[FX_W-2:0], bh};
    return o;
  endfunction

endpackage

[rtl/hsl_saturation_adjust_core.sv]
// Top level of the HSL saturation adjust core: a fully pipelined pixel datapath.
//
// Pixels enter on the s_axis channel and leave on the m_axis channel, one
// request per pixel, red in the lowest byte of tdata and the frame end flag
// on tlast. Each pixel is turned into hue, saturation and lightness, its
// saturation is scaled by 1.2 times intensity/256, and it is converted back.
// Gray pixels and all pixels while color is disabled pass unchanged.
// The pipeline has 25 register stages. Seventeen of them are the radix-2 steps
// of the two dividers for saturation and hue, the rest hold the input
// conversion, the multipliers and the back conversion.
// One pixel is accepted every cycle while the output is taken.
// When the receiver stalls a valid output, the whole pipeline holds and
// s_axis_tready_o drops in the same cycle; nothing is lost or repeated.
// The cfg channel is always ready; index 0 writes the intensity, index 1 the
// color enable. Write it only while the pipeline is empty.
// Reset empties the pipeline and sets intensity to 256 and color enable on.
module hsl_saturation_adjust_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // red_in, green_in, blue_in
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // red_out, green_out, blue_out
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

  localparam int unsigned FW = hsa_pkg::FX_W;
  localparam int unsigned DW = hsa_pkg::DEN_W;
  localparam int unsigned NDIV = hsa_pkg::DIV_STEPS;
  localparam int unsigned NITM = NDIV + 7;

  logic                        adv;
  logic [hsa_pkg::INT_W-1:0]   intensity_q;
  logic                        enable_q;

  hsa_pkg::item_t              itm_q [NITM];
  hsa_pkg::item_t              itm_d;
  logic [NITM-1:0]             vld_q;
  hsa_pkg::div_t               div_q [NDIV+1];
  hsa_pkg::div_t               div_in;
  hsa_pkg::div_t               div_d [1:NDIV];

  logic [FW-1:0] r_fx, g_fx, b_fx, mx, mn, diff, hmag;
  logic [DW-1:0] sum;

  assign adv = !(m_axis_tvalid_o && !m_axis_tready_i);
  assign s_axis_tready_o = adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intensity_q <= 10'd256;
      enable_q    <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hsa_pkg::CFG_INTENSITY: intensity_q <= cfg_data_i;
        hsa_pkg::CFG_ENABLE:    enable_q    <= cfg_data_i[0];
        default:                enable_q    <= enable_q;
      endcase
    end
  end

  always_comb begin
    r_fx = hsa_pkg::to_fx(s_axis_tdata_i[7:0]);
    g_fx = hsa_pkg::to_fx(s_axis_tdata_i[15:8]);
    b_fx = hsa_pkg::to_fx(s_axis_tdata_i[23:16]);
    mx = (r_fx > g_fx) ? r_fx : g_fx;
    if (b_fx > mx) begin
      mx = b_fx;
    end
    mn = (r_fx < g_fx) ? r_fx : g_fx;
    if (b_fx < mn) begin
      mn = b_fx;
    end
    sum  = DW'(mx) + DW'(mn);
    diff = mx - mn;
    itm_d.red    = s_axis_tdata_i[7:0];
    itm_d.green  = s_axis_tdata_i[15:8];
    itm_d.blue   = s_axis_tdata_i[23:16];
    itm_d.last   = s_axis_tlast_i;
    itm_d.bypass = !enable_q || ((s_axis_tdata_i[7:0] == s_axis_tdata_i[15:8])
                                 && (s_axis_tdata_i[15:8] == s_axis_tdata_i[23:16]));
    itm_d.light  = sum[DW-1:1];
    itm_d.wrap6  = 1'b0;
    if (mx == r_fx) begin
      itm_d.sector = hsa_pkg::SEC_RED;
      itm_d.hneg   = g_fx < b_fx;
      hmag         = itm_d.hneg ? b_fx - g_fx : g_fx - b_fx;
      itm_d.wrap6  = itm_d.hneg;
    end else if (mx == g_fx) begin
      itm_d.sector = hsa_pkg::SEC_GREEN;
      itm_d.hneg   = b_fx < r_fx;
      hmag         = itm_d.hneg ? r_fx - b_fx : b_fx - r_fx;
    end else begin
      itm_d.sector = hsa_pkg::SEC_BLUE;
      itm_d.hneg   = r_fx < g_fx;
      hmag         = itm_d.hneg ? g_fx - r_fx : r_fx - g_fx;
    end
    div_in.rem_s = DW'(diff);
    div_in.den_s = (itm_d.light > hsa_pkg::HALF) ? hsa_pkg::TWO - sum : sum;
    div_in.quo_s = '0;
    div_in.rem_h = DW'(hmag);
    div_in.den_h = DW'(diff);
    div_in.quo_h = '0;
  end

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    assign div_d[j+1] = hsa_pkg::div_step(div_q[j], j == 0);
  end

  // Post-divider stage signals.
  logic [18:0] off_a, h6_d, h6_q;
  logic [11:0] int3;
  logic [28:0] p1_d, p1_q;
  logic [36:0] hp;
  logic [42:0] p2;
  logic [FW-1:0] h_d, h_q, h_e_q;
  logic [18:0] s2r_d, s2r_q;
  logic [FW-1:0] s2_c, s2_q;
  logic [DW-1:0] mop;
  logic [34:0] p3_d, p3_q;
  logic lo_q;
  logic signed [20:0] q_d, p_d, q_q, p_q, qp_d, qp_q, p_e_q, p_f_q;
  logic [DW-1:0] tr;
  logic [FW-1:0] t_d [3];
  logic [FW-1:0] t_q [3];
  logic [FW-1:0] k_d [3];
  logic [FW-1:0] k_q [3];
  logic signed [38:0] pc_d [3];
  logic signed [38:0] pc_q [3];
  logic s2z_d, s2z_q, s2z_e_q, s2z_f_q;
  logic [7:0] byte_o [3];
  logic [23:0] data_d;

  always_comb begin
    unique case (itm_q[NDIV].sector)
      hsa_pkg::SEC_RED:   off_a = itm_q[NDIV].wrap6 ? 19'(6 * hsa_pkg::ONE) : '0;
      hsa_pkg::SEC_GREEN: off_a = 19'(2 * hsa_pkg::ONE);
      hsa_pkg::SEC_BLUE:  off_a = 19'(4 * hsa_pkg::ONE);
      default:            off_a = '0;
    endcase
    if (itm_q[NDIV].hneg) begin
      h6_d = off_a - 19'(div_q[NDIV].quo_h) - 19'(div_q[NDIV].rem_h != '0);
    end else begin
      h6_d = off_a + 19'(div_q[NDIV].quo_h);
    end
    int3 = {1'b0, intensity_q, 1'b0} + 12'(intensity_q);
    p1_d = 29'(div_q[NDIV].quo_s) * 29'(int3);
  end

  always_comb begin
    hp    = 37'(h6_q[18:1]) * 37'(hsa_pkg::RECIP3);
    h_d   = hp[36:20];
    p2    = 43'(p1_q[27:7]) * 43'(hsa_pkg::RECIP5);
    s2r_d = p2[42:24];
  end

  always_comb begin
    s2_c = (s2r_q > 19'(hsa_pkg::ONE)) ? hsa_pkg::ONE : s2r_q[FW-1:0];
    mop  = (itm_q[NDIV+2].light < hsa_pkg::HALF) ? DW'(hsa_pkg::ONE) + DW'(s2_c) : DW'(s2_c);
    p3_d = 35'(itm_q[NDIV+2].light) * 35'(mop);
  end

  always_comb begin
    if (lo_q) begin
      q_d = $signed({2'b0, p3_q[34:16]});
    end else begin
      q_d = $signed({4'b0, itm_q[NDIV+3].light}) + $signed({4'b0, s2_q})
          - $signed({2'b0, p3_q[34:16]});
    end
    p_d = $signed({3'b0, itm_q[NDIV+3].light, 1'b0}) - q_d;
    s2z_d = (s2_q == '0);
    tr = DW'(h_e_q) + DW'(hsa_pkg::THIRD);
    t_d[0] = (tr > DW'(hsa_pkg::ONE)) ? FW'(tr - DW'(hsa_pkg::ONE)) : tr[FW-1:0];
    t_d[1] = h_e_q;
    t_d[2] = (h_e_q < hsa_pkg::THIRD) ? h_e_q + hsa_pkg::ONE - hsa_pkg::THIRD
                                      : h_e_q - hsa_pkg::THIRD;
  end

  always_comb begin
    logic [FW-1:0] u;
    qp_d = q_q - p_q;
    for (int c = 0; c < 3; c++) begin
      u = hsa_pkg::TWO3 - t_q[c];
      if (t_q[c] < hsa_pkg::SIXTH) begin
        k_d[c] = FW'({t_q[c], 2'b0} + {1'b0, t_q[c], 1'b0});
      end else if (t_q[c] < hsa_pkg::HALF) begin
        k_d[c] = hsa_pkg::ONE;
      end else if (t_q[c] < hsa_pkg::TWO3) begin
        k_d[c] = FW'({u, 2'b0} + {1'b0, u, 1'b0});
      end else begin
        k_d[c] = '0;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pc_d[c] = 39'(qp_q * $signed({1'b0, k_q[c]}));
    end
  end

  always_comb begin
    logic signed [22:0] v;
    logic [FW-1:0]      vc;
    logic [24:0]        w;
    for (int c = 0; c < 3; c++) begin
      v = $signed({{2{p_f_q[20]}}, p_f_q}) + $signed(pc_q[c][38:16]);
      if (s2z_f_q) begin
        v = $signed({6'b0, itm_q[NDIV+6].light});
      end
      if (v < 0) begin
        vc = '0;
      end else if (v > $signed({6'b0, hsa_pkg::ONE})) begin
        vc = hsa_pkg::ONE;
      end else begin
        vc = v[FW-1:0];
      end
      w = {vc, 8'b0} - {8'b0, vc};
      byte_o[c] = w[23:16];
    end
    if (itm_q[NDIV+6].bypass) begin
      data_d = {itm_q[NDIV+6].blue, itm_q[NDIV+6].green, itm_q[NDIV+6].red};
    end else begin
      data_d = {byte_o[2], byte_o[1], byte_o[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q           <= '0;
      m_axis_tvalid_o <= 1'b0;
    end else if (adv) begin
      vld_q           <= {vld_q[NITM-2:0], s_axis_tvalid_i};
      m_axis_tvalid_o <= vld_q[NITM-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      itm_q[0] <= itm_d;
      div_q[0] <= div_in;
      for (int i = 1; i < NITM; i++) begin
        itm_q[i] <= itm_q[i-1];
      end
      for (int j = 1; j <= NDIV; j++) begin
        div_q[j] <= div_d[j];
      end
      h6_q    <= h6_d;
      p1_q    <= p1_d;
      h_q     <= h_d;
      h_e_q   <= h_q;
      s2r_q   <= s2r_d;
      s2_q    <= s2_c;
      p3_q    <= p3_d;
      lo_q    <= itm_q[NDIV+2].light < hsa_pkg::HALF;
      q_q     <= q_d;
      p_q     <= p_d;
      s2z_q   <= s2z_d;
      t_q     <= t_d;
      qp_q    <= qp_d;
      p_e_q   <= p_q;
      s2z_e_q <= s2z_q;
      k_q     <= k_d;
      pc_q    <= pc_d;
      p_f_q   <= p_e_q;
      s2z_f_q <= s2z_e_q;
      m_axis_tdata_o <= data_d;
      m_axis_tlast_o <= itm_q[NDIV+6].last;
    end
  end

endmodule

[sim/testbench.sv]
// Self-checking testbench of the HSL saturation adjust core with a fixed-point pixel predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FB    = 16;
  localparam longint      UNIT  = 64'sd1 << FB;
  localparam int          LAT   = 25;
  localparam int          LIMIT = 400000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  typedef struct {
    pixel_t pix;
    logic   known;
    pixel_t want;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [9:0]  cfg_data_i;

  hsl_saturation_adjust_core u_dut (.*);

  logic [9:0] gain_q8;
  logic       color_on;
  pixel_t     pending_pixels[$];
  int         fail_count;
  int         cycle_count;
  bit         hold_sink;
  int         hold_cycles;

  function automatic longint fdiv(longint num, longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic longint hue_level(longint p, longint q, longint t);
    if (t < 0) t += UNIT;
    if (t > UNIT) t -= UNIT;
    if (t < UNIT / 6) return p + fdiv((q - p) * 6 * t, UNIT);
    if (t < UNIT / 2) return q;
    if (t < (2 * UNIT) / 3) return p + fdiv((q - p) * ((2 * UNIT) / 3 - t) * 6, UNIT);
    return p;
  endfunction

  function automatic logic [7:0] fx_to_byte(longint v);
    if (v < 0) v = 0;
    if (v > UNIT) v = UNIT;
    return 8'(fdiv(v * 255, UNIT));
  endfunction

  function automatic pixel_t adjust_pixel(pixel_t pin);
    pixel_t o;
    longint r, g, b, mx, mn, d, l, s, h6, h, s2, p, q;
    o = pin;
    if (!color_on || (pin.red == pin.green && pin.green == pin.blue)) return o;
    r = (longint'(pin.red) * UNIT) / 255;
    g = (longint'(pin.green) * UNIT) / 255;
    b = (longint'(pin.blue) * UNIT) / 255;
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    l = (mx + mn) / 2;
    d = mx - mn;
    if (l > UNIT / 2) s = (d * UNIT) / (2 * UNIT - mx - mn);
    else s = (d * UNIT) / (mx + mn);
    if (mx == r) h6 = fdiv((g - b) * UNIT, d) + ((g < b) ? 6 * UNIT : 0);
    else if (mx == g) h6 = fdiv((b - r) * UNIT, d) + 2 * UNIT;
    else h6 = fdiv((r - g) * UNIT, d) + 4 * UNIT;
    h = fdiv(h6, 6);
    s2 = (s * longint'(gain_q8) * 3) / 640;
    if (s2 > UNIT) s2 = UNIT;
    if (s2 == 0) begin
      o.red = fx_to_byte(l);
      o.green = fx_to_byte(l);
      o.blue = fx_to_byte(l);
      return o;
    end
    if (l < UNIT / 2) q = fdiv(l * (UNIT + s2), UNIT);
    else q = l + s2 - fdiv(l * s2, UNIT);
    p = 2 * l - q;
    o.red = fx_to_byte(hue_level(p, q, h + UNIT / 3));
    o.green = fx_to_byte(hue_level(p, q, h));
    o.blue = fx_to_byte(hue_level(p, q, h - UNIT / 3));
    return o;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    pixel_t got;
    pixel_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[7:0], m_axis_tdata_o[15:8], m_axis_tdata_o[23:16], m_axis_tlast_o};
      if (pending_pixels.size() == 0) begin
        $error("unexpected output pixel %h", got);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red) begin
          $error("red_out: expected %0d, actual %0d", want.red, got.red);
          fail_count++;
        end
        if (got.green !== want.green) begin
          $error("green_out: expected %0d, actual %0d", want.green, got.green);
          fail_count++;
        end
        if (got.blue !== want.blue) begin
          $error("blue_out: expected %0d, actual %0d", want.blue, got.blue);
          fail_count++;
        end
        if (got.last !== want.last) begin
          $error("last_out: expected %0d, actual %0d", want.last, got.last);
          fail_count++;
        end
      end
    end
  end

  // Sink side: random stalls per pixel, plus one long hold-off on request.
  initial begin
    int wait_n;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (wait_n > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [9:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == hsa_pkg::CFG_INTENSITY) gain_q8 = value;
    else color_on = value[0];
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input pixel_t pin, input int gap);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {pin.blue, pin.green, pin.red};
    s_axis_tlast_i <= pin.last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_pixels.push_back(adjust_pixel(pin));
  endtask

  task automatic drain_pipe();
    s_axis_tvalid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (LAT + 5) @(posedge clk_i);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    int kind;
    px = pixel_t'(25'($urandom));
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      px.green = px.red;
      px.blue = px.red;
    end else if (kind == 1) begin
      px.green = px.red;
    end else if (kind == 2) begin
      px.blue = 8'($urandom_range(0, 1) ? 255 : 0);
    end
    px.last = ($urandom_range(0, 15) == 0);
    return px;
  endfunction

  row_t directed[$];

  initial begin
    row_t rw;
    pixel_t got_want;
    int n;
    int gains[6];
    gains = '{0, 1, 255, 512, 853, 1023};
    fail_count = 0;
    cycle_count = 0;
    hold_sink = 1'b0;
    hold_cycles = 0;
    gain_q8 = 10'd256;
    color_on = 1'b1;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tlast_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = hsa_pkg::CFG_INTENSITY;
    cfg_data_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Gray, black and white have results that follow by inspection.
    directed = '{
      '{'{8'd0, 8'd0, 8'd0, 1'b0}, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
      '{'{8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}},
      '{'{8'd128, 8'd128, 8'd128, 1'b0}, 1'b1, '{8'd128, 8'd128, 8'd128, 1'b0}},
      '{'{8'd255, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
      '{'{8'd0, 8'd255, 8'd0, 1'b0}, 1'b0, '0},
      '{'{8'd0, 8'd0, 8'd255, 1'b1}, 1'b0, '0},
      '{'{8'd255, 8'd255, 8'd0, 1'b0}, 1'b0, '0},
      '{'{8'd0, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
      '{'{8'd255, 8'd0, 8'd255, 1'b0}, 1'b0, '0},
      '{'{8'd200, 8'd50, 8'd100, 1'b0}, 1'b0, '0},
      '{'{8'd1, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
      '{'{8'd254, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
      '{'{8'd170, 8'd85, 8'd85, 1'b0}, 1'b0, '0},
      '{'{8'd10, 8'd200, 8'd30, 1'b1}, 1'b0, '0}
    };
    foreach (directed[i]) begin
      rw = directed[i];
      send_pixel(rw.pix, 0);
      if (rw.known) begin
        got_want = pending_pixels[$];
        if (got_want !== rw.want) begin
          $error("predicted pixel: expected %h, actual %h", rw.want, got_want);
          fail_count++;
        end
      end
    end
    drain_pipe();

    foreach (gains[k]) begin
      write_reg(hsa_pkg::CFG_INTENSITY, 10'(gains[k]));
      write_reg(hsa_pkg::CFG_ENABLE, 10'(k != 2));
      n = (k == 3) ? 200 : 90;
      for (int j = 0; j < n; j++) begin
        if (k == 3 && j == 20) begin
          hold_cycles = 120;
          hold_sink = 1'b1;
        end
        if (j % 50 == 49) begin
          s_axis_tvalid_i <= 1'b0;
          while (pending_pixels.size() != 0) @(posedge clk_i);
        end
        send_pixel(random_pixel(), (j % 40 < 15) ? 0 : $urandom_range(0, 8));
      end
      drain_pipe();
    end
    write_reg(hsa_pkg::CFG_INTENSITY, 10'd256);
    write_reg(hsa_pkg::CFG_ENABLE, 10'd1);
    for (int j = 0; j < 40; j++) send_pixel(random_pixel(), $urandom_range(0, 8));
    drain_pipe();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/hsa_pkg.sv
rtl/hsl_saturation_adjust_core.sv
sim/testbench.sv
